// ----- sv/dimstr_pkg.sv -----
// Shared types, codes and constants for the dimension string parser.
`timescale 1ns / 1ps
package dimstr_pkg;

	localparam int DEF_WHOLE_BITS      = 32;
	localparam int DEF_FRACTION_BITS   = 24;
	localparam int DEF_FRACTION_DIGITS = 7;
	localparam int QUEUE_DEPTH         = 2;

	// Character classes produced by the front end.
	localparam logic [2:0] CLS_SKIP  = 3'd0;
	localparam logic [2:0] CLS_DIGIT = 3'd1;
	localparam logic [2:0] CLS_SEP   = 3'd2;
	localparam logic [2:0] CLS_WS    = 3'd3;
	localparam logic [2:0] CLS_OTHER = 3'd4;

	// Letters that may appear in a unit.
	localparam logic [2:0] LET_NONE = 3'd0;
	localparam logic [2:0] LET_E    = 3'd1;
	localparam logic [2:0] LET_M    = 3'd2;
	localparam logic [2:0] LET_C    = 3'd3;
	localparam logic [2:0] LET_P    = 3'd4;
	localparam logic [2:0] LET_T    = 3'd5;
	localparam logic [2:0] LET_X    = 3'd6;

	// Parser phases.
	localparam logic [2:0] PH_LEAD  = 3'd0;
	localparam logic [2:0] PH_INT   = 3'd1;
	localparam logic [2:0] PH_SEP   = 3'd2;
	localparam logic [2:0] PH_FRAC  = 3'd3;
	localparam logic [2:0] PH_MID   = 3'd4;
	localparam logic [2:0] PH_UNIT1 = 3'd5;
	localparam logic [2:0] PH_TAIL  = 3'd6;

	// Unit codes as reported.
	localparam logic [2:0] UNIT_PX = 3'd0;
	localparam logic [2:0] UNIT_EM = 3'd1;
	localparam logic [2:0] UNIT_MM = 3'd2;
	localparam logic [2:0] UNIT_CM = 3'd3;
	localparam logic [2:0] UNIT_PT = 3'd4;

	typedef struct packed {
		logic       last;
		logic [2:0] cls;
		logic [2:0] letter;
		logic [3:0] digit;
	} token_t;

	function automatic logic [63:0] pow10(int k);
		logic [63:0] p;
		p = 64'd1;
		for (int i = 0; i < k; i++) begin
			p = p * 64'd10;
		end
		return p;
	endfunction

endpackage

// ----- sv/dimstr_front.sv -----
// Front end: accepts character beats, classifies them and tracks string termination.
`timescale 1ns / 1ps
module dimstr_front (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 char_valid,
	output logic                 char_ready,
	input  logic [7:0]           character,
	input  logic                 final_req,
	input  logic                 q_full,
	output logic                 push,
	output dimstr_pkg::token_t   tok
);
	import dimstr_pkg::*;

	logic terminated_q;
	logic accept;

	assign char_ready = !q_full;
	assign accept     = char_valid && char_ready;
	assign push       = accept;

	always_comb begin
		tok.last   = final_req;
		tok.digit  = character[3:0];
		tok.letter = LET_NONE;
		case (character)
			8'h65:   tok.letter = LET_E;
			8'h6D:   tok.letter = LET_M;
			8'h63:   tok.letter = LET_C;
			8'h70:   tok.letter = LET_P;
			8'h74:   tok.letter = LET_T;
			8'h78:   tok.letter = LET_X;
			default: tok.letter = LET_NONE;
		endcase
		if (terminated_q || character == 8'h00) begin
			tok.cls = CLS_SKIP;
		end else if (character inside {[8'h30:8'h39]}) begin
			tok.cls = CLS_DIGIT;
		end else if (character inside {8'h2E, 8'h2C}) begin
			tok.cls = CLS_SEP;
		end else if (character inside {8'h20, [8'h09:8'h0D]}) begin
			tok.cls = CLS_WS;
		end else begin
			tok.cls = CLS_OTHER;
		end
	end

	// A zero byte ends the string; everything up to the final beat is then ignored.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			terminated_q <= 1'b0;
		end else if (accept) begin
			if (final_req) begin
				terminated_q <= 1'b0;
			end else if (character == 8'h00) begin
				terminated_q <= 1'b1;
			end
		end
	end

endmodule

// ----- sv/dimstr_queue.sv -----
// Short token queue between the front end and the back end.
`timescale 1ns / 1ps
module dimstr_queue (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 push,
	input  dimstr_pkg::token_t   push_tok,
	output logic                 full,
	input  logic                 pop,
	output logic                 head_valid,
	output dimstr_pkg::token_t   head_tok
);
	import dimstr_pkg::*;

	localparam int PW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int CW = $clog2(QUEUE_DEPTH + 1);

	token_t        slot_q [QUEUE_DEPTH];
	logic [PW-1:0] wr_ptr_q;
	logic [PW-1:0] rd_ptr_q;
	logic [CW-1:0] count_q;
	logic          do_push;
	logic          do_pop;

	assign full       = (count_q == CW'(QUEUE_DEPTH));
	assign head_valid = (count_q != '0);
	assign head_tok   = slot_q[rd_ptr_q];
	assign do_push    = push && !full;
	assign do_pop     = pop && head_valid;

	always_ff @(posedge clk) begin
		if (do_push) begin
			slot_q[wr_ptr_q] <= push_tok;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			case ({do_push, do_pop})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(QUEUE_DEPTH))
		else $error("queue fill count beyond depth");

	a_count_track: assert property (@(posedge clk) disable iff (!arst_n)
		(do_push && !do_pop) |=> count_q == $past(count_q) + 1'b1)
		else $error("queue count missed a push");

	a_pop_empty: assert property (@(posedge clk) disable iff (!arst_n)
		(count_q == '0) |-> !do_pop)
		else $error("pop from an empty queue");

endmodule

// ----- sv/dimstr_back.sv -----
// Back end: runs the grammar over classified tokens, accumulates the value and holds the result.
`timescale 1ns / 1ps
module dimstr_back #(
	parameter int WHOLE_BITS      = dimstr_pkg::DEF_WHOLE_BITS,
	parameter int FRACTION_BITS   = dimstr_pkg::DEF_FRACTION_BITS,
	parameter int FRACTION_DIGITS = dimstr_pkg::DEF_FRACTION_DIGITS
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     tok_valid,
	input  dimstr_pkg::token_t       tok,
	output logic                     tok_pop,
	output logic                     result_valid,
	input  logic                     result_ready,
	output logic                     accepted,
	output logic [2:0]               unit_code,
	output logic [WHOLE_BITS-1:0]    whole_part,
	output logic [FRACTION_BITS-1:0] fraction_part
);
	import dimstr_pkg::*;

	localparam int WB = WHOLE_BITS;
	localparam int FB = FRACTION_BITS;
	localparam int CW = $clog2(FRACTION_DIGITS + 1);

	// Weight of the k-th fraction digit: 2^FB / 10^k rounded half up.
	logic [FB-1:0] weight_tab [FRACTION_DIGITS+1];
	for (genvar k = 0; k < FRACTION_DIGITS; k++) begin : g_weight
		localparam logic [63:0] P = pow10(k + 1);
		localparam logic [63:0] W = ((64'd1 << FB) + P / 64'd2) / P;
		assign weight_tab[k] = W[FB-1:0];
	end
	assign weight_tab[FRACTION_DIGITS] = '0;

	logic [2:0]    phase_q, phase_d;
	logic [WB-1:0] whole_q, whole_d;
	logic [FB-1:0] frac_q, frac_d;
	logic [CW-1:0] ndig_q, ndig_d;
	logic [2:0]    first_q, first_d;
	logic [2:0]    unit_q, unit_d;
	logic          failed_q, failed_d;

	logic          res_valid_q;
	logic          res_ok_q;
	logic [2:0]    res_unit_q;
	logic [WB-1:0] res_whole_q;
	logic [FB-1:0] res_frac_q;

	logic            out_free;
	logic            fire;
	logic            start_ok;
	logic            ok;
	logic [WB+3:0]   whole_x10;
	logic [WB-1:0]   whole_next;
	logic [FB+3:0]   frac_prod;
	logic [FB+4:0]   frac_sum;
	logic [FB-1:0]   frac_next;
	logic            frac_room;

	assign out_free = !res_valid_q || result_ready;
	assign fire     = tok_valid && (!tok.last || out_free);
	assign tok_pop  = fire;

	assign whole_x10 = {1'b0, whole_q, 3'b000} + {3'b000, whole_q, 1'b0}
		+ {{WB{1'b0}}, tok.digit};
	assign whole_next = (whole_x10[WB+3:WB] != 4'd0) ? {WB{1'b1}} : whole_x10[WB-1:0];

	assign frac_room = (ndig_q < CW'(FRACTION_DIGITS));
	assign frac_prod = {{FB{1'b0}}, tok.digit} * {4'b0000, weight_tab[ndig_q]};
	assign frac_sum  = {5'b00000, frac_q} + {1'b0, frac_prod};
	assign frac_next = (frac_sum[FB+4:FB] != 5'd0) ? {FB{1'b1}} : frac_sum[FB-1:0];

	assign start_ok = (tok.letter inside {LET_E, LET_M, LET_C, LET_P});

	always_comb begin
		phase_d  = phase_q;
		whole_d  = whole_q;
		frac_d   = frac_q;
		ndig_d   = ndig_q;
		first_d  = first_q;
		unit_d   = unit_q;
		failed_d = failed_q;
		if (tok.cls != CLS_SKIP && !failed_q) begin
			case (phase_q)
				PH_LEAD, PH_INT: begin
					if (tok.cls == CLS_DIGIT) begin
						whole_d = whole_next;
						phase_d = PH_INT;
					end else if (tok.cls == CLS_SEP) begin
						phase_d = PH_SEP;
					end else if (tok.cls == CLS_WS) begin
						if (phase_q == PH_INT) begin
							phase_d = PH_MID;
						end
					end else if (start_ok) begin
						first_d = tok.letter;
						phase_d = PH_UNIT1;
					end else begin
						failed_d = 1'b1;
					end
				end
				PH_SEP, PH_FRAC: begin
					if (tok.cls == CLS_DIGIT) begin
						phase_d = PH_FRAC;
						if (frac_room) begin
							frac_d = frac_next;
							ndig_d = ndig_q + 1'b1;
						end
					end else if (phase_q == PH_SEP) begin
						failed_d = 1'b1;
					end else if (tok.cls == CLS_WS) begin
						phase_d = PH_MID;
					end else if (start_ok) begin
						first_d = tok.letter;
						phase_d = PH_UNIT1;
					end else begin
						failed_d = 1'b1;
					end
				end
				PH_MID: begin
					if (tok.cls != CLS_WS) begin
						if (start_ok) begin
							first_d = tok.letter;
							phase_d = PH_UNIT1;
						end else begin
							failed_d = 1'b1;
						end
					end
				end
				PH_UNIT1: begin
					phase_d = PH_TAIL;
					if (first_q == LET_E && tok.letter == LET_M) begin
						unit_d = UNIT_EM;
					end else if (first_q == LET_M && tok.letter == LET_M) begin
						unit_d = UNIT_MM;
					end else if (first_q == LET_C && tok.letter == LET_M) begin
						unit_d = UNIT_CM;
					end else if (first_q == LET_P && tok.letter == LET_T) begin
						unit_d = UNIT_PT;
					end else if (first_q == LET_P && tok.letter == LET_X) begin
						unit_d = UNIT_PX;
					end else begin
						failed_d = 1'b1;
					end
				end
				PH_TAIL: begin
					if (tok.cls != CLS_WS) begin
						failed_d = 1'b1;
					end
				end
				default: failed_d = 1'b1;
			endcase
		end
		ok = !failed_d && (phase_d inside {PH_INT, PH_FRAC, PH_MID, PH_TAIL});
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q  <= PH_LEAD;
			whole_q  <= '0;
			frac_q   <= '0;
			ndig_q   <= '0;
			first_q  <= LET_NONE;
			unit_q   <= UNIT_PX;
			failed_q <= 1'b0;
		end else if (fire) begin
			if (tok.last) begin
				phase_q  <= PH_LEAD;
				whole_q  <= '0;
				frac_q   <= '0;
				ndig_q   <= '0;
				first_q  <= LET_NONE;
				unit_q   <= UNIT_PX;
				failed_q <= 1'b0;
			end else begin
				phase_q  <= phase_d;
				whole_q  <= whole_d;
				frac_q   <= frac_d;
				ndig_q   <= ndig_d;
				first_q  <= first_d;
				unit_q   <= unit_d;
				failed_q <= failed_d;
			end
		end
	end

	// Result register: a rejected string reports all fields as zero.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (fire && tok.last) begin
			res_valid_q <= 1'b1;
		end else if (result_ready) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (fire && tok.last) begin
			res_ok_q    <= ok;
			res_unit_q  <= ok ? unit_d : UNIT_PX;
			res_whole_q <= ok ? whole_d : '0;
			res_frac_q  <= ok ? frac_d : '0;
		end
	end

	assign result_valid  = res_valid_q;
	assign accepted      = res_ok_q;
	assign unit_code     = res_unit_q;
	assign whole_part    = res_whole_q;
	assign fraction_part = res_frac_q;

	a_reject_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(res_valid_q && !res_ok_q) |->
			(res_unit_q == UNIT_PX && res_whole_q == '0 && res_frac_q == '0))
		else $error("rejected string carries a non-zero value");

	a_digit_bound: assert property (@(posedge clk) disable iff (!arst_n)
		ndig_q <= CW'(FRACTION_DIGITS))
		else $error("fraction digit count beyond limit");

	a_result_held: assert property (@(posedge clk) disable iff (!arst_n)
		(res_valid_q && !result_ready) |=> (res_valid_q && $stable(res_whole_q)
			&& $stable(res_frac_q) && $stable(res_ok_q)))
		else $error("pending result overwritten");

endmodule

// ----- sv/dimension_string_parser.sv -----
// Top level of the dimension string parser: front end, token queue and back end.
`timescale 1ns / 1ps
// Reads a length string such as "12.5 mm" one character beat at a time and, on the
// beat flagged by final_req, returns one result beat with the verdict, the unit code
// (pixel when none is written), the saturating integer part and the binary fraction.
// Characters are accepted at one per cycle while the token queue has room; the back
// end runs its grammar and accumulate step on each token it takes. A result is
// registered once its final beat has passed through the two-entry queue, and that
// beat waits at the queue head while an earlier result is untaken, so the queue can fill.
// While a result waits to be taken, the queue keeps accepting characters, and the back
// end keeps consuming them until it meets the next final beat.
module dimension_string_parser #(
	parameter int WHOLE_BITS      = dimstr_pkg::DEF_WHOLE_BITS,
	parameter int FRACTION_BITS   = dimstr_pkg::DEF_FRACTION_BITS,
	parameter int FRACTION_DIGITS = dimstr_pkg::DEF_FRACTION_DIGITS
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     char_valid,
	output logic                     char_ready,
	input  logic [7:0]               character,
	input  logic                     final_req,
	output logic                     result_valid,
	input  logic                     result_ready,
	output logic                     accepted,
	output logic [2:0]               unit_code,
	output logic [WHOLE_BITS-1:0]    whole_part,
	output logic [FRACTION_BITS-1:0] fraction_part
);
	import dimstr_pkg::*;

	token_t front_tok;
	token_t head_tok;
	logic   push;
	logic   q_full;
	logic   head_valid;
	logic   pop;

	dimstr_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.char_valid (char_valid),
		.char_ready (char_ready),
		.character  (character),
		.final_req  (final_req),
		.q_full     (q_full),
		.push       (push),
		.tok        (front_tok)
	);

	dimstr_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_tok   (front_tok),
		.full       (q_full),
		.pop        (pop),
		.head_valid (head_valid),
		.head_tok   (head_tok)
	);

	dimstr_back #(
		.WHOLE_BITS      (WHOLE_BITS),
		.FRACTION_BITS   (FRACTION_BITS),
		.FRACTION_DIGITS (FRACTION_DIGITS)
	) u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.tok_valid     (head_valid),
		.tok           (head_tok),
		.tok_pop       (pop),
		.result_valid  (result_valid),
		.result_ready  (result_ready),
		.accepted      (accepted),
		.unit_code     (unit_code),
		.whole_part    (whole_part),
		.fraction_part (fraction_part)
	);

endmodule

// ----- test/tb_dimension_string_parser.sv -----
// Self-checking testbench for the dimension string parser, with its scoreboard class.
`timescale 1ns / 1ps
module tb_dimension_string_parser;
	import dimstr_pkg::*;

	localparam int WB = DEF_WHOLE_BITS;
	localparam int FB = DEF_FRACTION_BITS;
	localparam int FD = DEF_FRACTION_DIGITS;
	localparam int CHAR_TARGET = 650;
	localparam int QUIET_FROM  = 560;
	localparam int CYCLE_LIMIT = 200000;
	localparam int DRAIN_CYCLES = 8;

	localparam bit [7:0] CH_NUL   = 8'h00;
	localparam bit [7:0] CH_TAB   = 8'h09;
	localparam bit [7:0] CH_CR    = 8'h0D;
	localparam bit [7:0] CH_SPACE = 8'h20;
	localparam bit [7:0] CH_COMMA = 8'h2C;
	localparam bit [7:0] CH_DOT   = 8'h2E;
	localparam bit [7:0] CH_0     = 8'h30;
	localparam bit [7:0] CH_9     = 8'h39;
	localparam bit [7:0] CH_TOP   = 8'hFF;
	localparam bit [7:0] CH_C     = "c";
	localparam bit [7:0] CH_E     = "e";
	localparam bit [7:0] CH_M     = "m";
	localparam bit [7:0] CH_P     = "p";
	localparam bit [7:0] CH_T     = "t";
	localparam bit [7:0] CH_X     = "x";

	typedef bit [7:0] byte_q_t[$];

	typedef struct packed {
		logic          ok;
		logic [2:0]    unit;
		logic [WB-1:0] whole;
		logic [FB-1:0] frac;
	} length_result_t;

	class length_scoreboard;
		length_result_t expected_lengths[$];
		int errors;
		int strings_seen;
		int strings_good;

		bit [2:0]  phase;
		bit [63:0] whole_acc;
		bit [63:0] frac_acc;
		int        frac_count;
		bit [7:0]  unit_first;
		bit [2:0]  unit_seen;
		bit        failed;
		bit        ended;

		function new();
			errors = 0;
			strings_seen = 0;
			strings_good = 0;
			clear();
		endfunction

		function void clear();
			phase = PH_LEAD;
			whole_acc = 0;
			frac_acc = 0;
			frac_count = 0;
			unit_first = CH_NUL;
			unit_seen = UNIT_PX;
			failed = 0;
			ended = 0;
		endfunction

		function int pending();
			return expected_lengths.size();
		endfunction

		function bit is_digit(bit [7:0] c);
			return c >= CH_0 && c <= CH_9;
		endfunction

		function bit is_space(bit [7:0] c);
			return c == CH_SPACE || (c >= CH_TAB && c <= CH_CR);
		endfunction

		function void add_whole(bit [63:0] d);
			bit [63:0] top;
			top = 64'hFFFF_FFFF_FFFF_FFFF >> (64 - WB);
			if (whole_acc > (top - d) / 10)
				whole_acc = top;
			else
				whole_acc = whole_acc * 10 + d;
		endfunction

		// The k-th digit is worth 2^FB / 10^k, rounded half up.
		function void add_fraction(bit [63:0] d);
			bit [63:0] p;
			if (frac_count >= FD)
				return;
			frac_count++;
			p = 1;
			repeat (frac_count) p = p * 10;
			frac_acc = frac_acc + d * (((64'd1 << FB) + p / 2) / p);
			if (frac_acc > (64'd1 << FB) - 1)
				frac_acc = (64'd1 << FB) - 1;
		endfunction

		function void start_unit(bit [7:0] c);
			if (c == CH_E || c == CH_M || c == CH_C || c == CH_P) begin
				unit_first = c;
				phase = PH_UNIT1;
			end else begin
				failed = 1;
			end
		endfunction

		function void finish_unit(bit [7:0] c);
			phase = PH_TAIL;
			if (unit_first == CH_E && c == CH_M) unit_seen = UNIT_EM;
			else if (unit_first == CH_M && c == CH_M) unit_seen = UNIT_MM;
			else if (unit_first == CH_C && c == CH_M) unit_seen = UNIT_CM;
			else if (unit_first == CH_P && c == CH_T) unit_seen = UNIT_PT;
			else if (unit_first == CH_P && c == CH_X) unit_seen = UNIT_PX;
			else failed = 1;
		endfunction

		function void take_char(bit [7:0] c);
			case (phase)
				PH_LEAD, PH_INT: begin
					if (is_digit(c)) begin
						add_whole(64'(c - CH_0));
						phase = PH_INT;
					end else if (c == CH_DOT || c == CH_COMMA) begin
						phase = PH_SEP;
					end else if (is_space(c)) begin
						if (phase == PH_INT)
							phase = PH_MID;
					end else begin
						start_unit(c);
					end
				end
				PH_SEP: begin
					if (is_digit(c)) begin
						add_fraction(64'(c - CH_0));
						phase = PH_FRAC;
					end else begin
						failed = 1;
					end
				end
				PH_FRAC: begin
					if (is_digit(c))
						add_fraction(64'(c - CH_0));
					else if (is_space(c))
						phase = PH_MID;
					else
						start_unit(c);
				end
				PH_MID: begin
					if (!is_space(c))
						start_unit(c);
				end
				PH_UNIT1: finish_unit(c);
				PH_TAIL: begin
					if (!is_space(c))
						failed = 1;
				end
				default: failed = 1;
			endcase
		endfunction

		// A zero byte ends the string; anything after it up to the final beat is ignored.
		function void note_char(bit [7:0] c, bit fin);
			length_result_t r;
			if (!ended && !failed) begin
				if (c == CH_NUL)
					ended = 1;
				else
					take_char(c);
			end
			if (!fin)
				return;
			r = '0;
			r.ok = !failed && (phase == PH_INT || phase == PH_FRAC ||
				phase == PH_MID || phase == PH_TAIL);
			if (r.ok) begin
				r.unit = unit_seen;
				r.whole = whole_acc[WB-1:0];
				r.frac = frac_acc[FB-1:0];
				strings_good++;
			end
			strings_seen++;
			expected_lengths.push_back(r);
			clear();
		endfunction

		function void report(string field, longint unsigned want, longint unsigned got);
			errors++;
			$display("%0t: %s expected %0d, got %0d", $time, field, want, got);
		endfunction

		function void check_result(logic ok, logic [2:0] unit, logic [WB-1:0] whole,
			logic [FB-1:0] frac);
			length_result_t want;
			if (expected_lengths.size() == 0) begin
				errors++;
				$display("%0t: result beat with nothing expected (accepted %0d, unit %0d)",
					$time, ok, unit);
				return;
			end
			want = expected_lengths.pop_front();
			if (ok !== want.ok) report("accepted", want.ok, ok);
			if (unit !== want.unit) report("unit_code", want.unit, unit);
			if (whole !== want.whole) report("whole_part", want.whole, whole);
			if (frac !== want.frac) report("fraction_part", want.frac, frac);
		endfunction
	endclass

	logic          clk;
	logic          arst_n;
	logic          char_valid;
	logic          char_ready;
	logic [7:0]    character;
	logic          final_req;
	logic          result_valid;
	logic          result_ready;
	logic          accepted;
	logic [2:0]    unit_code;
	logic [WB-1:0] whole_part;
	logic [FB-1:0] fraction_part;

	length_scoreboard sb;
	bit quiet;
	int chars_sent;
	int cycle_count;

	dimension_string_parser u_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.char_valid   (char_valid),
		.char_ready   (char_ready),
		.character    (character),
		.final_req    (final_req),
		.result_valid (result_valid),
		.result_ready (result_ready),
		.accepted     (accepted),
		.unit_code    (unit_code),
		.whole_part   (whole_part),
		.fraction_part(fraction_part)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	// Receiver: takes results freely, with short stalls except in the last part of the run.
	initial begin : result_sink
		int stall_left;
		stall_left = 0;
		result_ready = 1'b0;
		forever begin
			@(negedge clk);
			if (stall_left > 0) begin
				result_ready <= 1'b0;
				stall_left--;
			end else begin
				result_ready <= 1'b1;
				if (!quiet && arst_n && $urandom_range(0, 5) == 0)
					stall_left = $urandom_range(1, 4);
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n && result_valid && result_ready)
			sb.check_result(accepted, unit_code, whole_part, fraction_part);
	end

	initial begin : watchdog
		for (cycle_count = 0; cycle_count < CYCLE_LIMIT; cycle_count++)
			@(posedge clk);
		$display("dimension_string_parser regression: fail");
		$finish;
	end

	task automatic send_char(bit [7:0] c, bit fin);
		if (!quiet && $urandom_range(0, 4) == 0) begin
			char_valid <= 1'b0;
			repeat ($urandom_range(1, 4)) @(negedge clk);
		end
		char_valid <= 1'b1;
		character <= c;
		final_req <= fin;
		do @(posedge clk); while (!char_ready);
		sb.note_char(c, fin);
		chars_sent++;
		@(negedge clk);
	endtask

	task automatic send_bytes(byte_q_t q);
		for (int i = 0; i < q.size(); i++)
			send_char(q[i], i == q.size() - 1);
	endtask

	task automatic hold_until_drained();
		char_valid <= 1'b0;
		while (sb.pending() != 0) @(posedge clk);
		@(negedge clk);
	endtask

	function automatic byte_q_t text(string s);
		byte_q_t q;
		for (int i = 0; i < s.len(); i++)
			q.push_back(s[i]);
		return q;
	endfunction

	function automatic bit [7:0] random_space();
		int r;
		r = $urandom_range(0, 5);
		return (r == 5) ? CH_SPACE : 8'(CH_TAB + r);
	endfunction

	function automatic byte_q_t random_digits(int n);
		byte_q_t q;
		repeat (n) q.push_back(8'(CH_0 + $urandom_range(0, 9)));
		return q;
	endfunction

	// Mostly well-formed lengths with random content; the rest corrupted or plain noise.
	function automatic byte_q_t random_length();
		byte_q_t q;
		string unit_names[5] = '{"em", "mm", "cm", "pt", "px"};
		int kind;
		int n;
		kind = $urandom_range(0, 99);
		if (kind >= 85) begin
			repeat ($urandom_range(1, 5)) q.push_back(8'($urandom_range(0, 255)));
			return q;
		end
		repeat ($urandom_range(0, 2)) q.push_back(random_space());
		n = $urandom_range(0, 9);
		q = {q, random_digits(n == 9 ? $urandom_range(10, 12) : (n == 0 ? 0 : $urandom_range(1, 3)))};
		if ($urandom_range(0, 1)) begin
			q.push_back($urandom_range(0, 1) ? CH_DOT : CH_COMMA);
			q = {q, random_digits($urandom_range(0, 9) == 0 ? $urandom_range(7, 9)
				: $urandom_range(1, 3))};
		end
		if ($urandom_range(0, 2) == 0) q.push_back(random_space());
		if ($urandom_range(0, 4) < 3) q = {q, text(unit_names[$urandom_range(0, 4)])};
		if ($urandom_range(0, 3) == 0) q.push_back(random_space());
		if (q.size() == 0) q.push_back(CH_0);
		if (kind >= 70) begin
			n = $urandom_range(0, q.size() - 1);
			q[n] = ($urandom_range(0, 3) == 0) ? CH_NUL : 8'($urandom_range(0, 255));
		end
		return q;
	endfunction

	initial begin : stimulus
		byte_q_t q;
		int strings_sent;
		sb = new();
		quiet = 0;
		chars_sent = 0;
		strings_sent = 0;
		arst_n = 1'b0;
		char_valid = 1'b0;
		character = 8'h00;
		final_req = 1'b0;
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		send_bytes(text(".5em"));
		send_bytes(text("mm"));
		send_bytes(text("5."));
		send_bytes(text("\t "));
		send_bytes(text("-1"));
		send_bytes(text("3c"));
		send_bytes(text("2PT"));
		send_bytes(text("1 px "));
		send_bytes(text("4294967296"));
		q = text("8");
		q.push_back(CH_NUL);
		q.push_back(CH_TOP);
		send_bytes(q);
		q = text("6");
		q.push_back(CH_NUL);
		send_bytes(q);
		q = '{CH_NUL};
		send_bytes(q);
		hold_until_drained();

		while (chars_sent < CHAR_TARGET) begin
			if (chars_sent >= QUIET_FROM)
				quiet = 1;
			send_bytes(random_length());
			strings_sent++;
			if (!quiet && strings_sent % 30 == 0)
				hold_until_drained();
		end

		hold_until_drained();
		repeat (DRAIN_CYCLES) @(posedge clk);
		$display("Sent %0d character beats forming %0d strings; %0d parsed as valid lengths.",
			chars_sent, sb.strings_seen, sb.strings_good);
		$display("Covered all five units, empty integer parts, saturation, zero bytes and noise.");
		if (sb.errors == 0)
			$display("dimension_string_parser regression: pass");
		else
			$display("dimension_string_parser regression: fail");
		$finish;
	end
endmodule

// ----- dimension_string_parser.f -----
sv/dimstr_pkg.sv
sv/dimstr_front.sv
sv/dimstr_queue.sv
sv/dimstr_back.sv
sv/dimension_string_parser.sv
test/tb_dimension_string_parser.sv
